// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checkers of this block.
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SALRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SALRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/salru_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// salru_pkg
// Shared constants, codes and types of the set-associative LRU cache tracker.
// ---------------------------------------------------------------------------
package salru_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_WIDTH   = 64;

  localparam int ADDR_FIELD_W = 64;
  localparam int OP_W         = 2;
  localparam int OUTC_W       = 2;
  localparam int CNT_W        = 32;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 4;
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_W       = 4;

  localparam int BLOCK_BITS_MAX = 16;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;

  // register index (byte address / 4)
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_MISS  = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic done;
    logic hit;
    logic free;
  } scan_stat_t;

endpackage

// ----- rtl/salru_ifs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// salru_ifs
// Access and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface salru_req_if;
  logic                              valid;
  logic                              ready;
  logic [salru_pkg::OP_W-1:0]        operation;
  logic [salru_pkg::ADDR_FIELD_W-1:0] address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

interface salru_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [salru_pkg::OUTC_W-1:0] outcome;
  logic                         extra_hit;
  logic [salru_pkg::CNT_W-1:0]  hit_total;
  logic [salru_pkg::CNT_W-1:0]  miss_total;
  logic [salru_pkg::CNT_W-1:0]  eviction_total;

  modport source (output valid, outcome, extra_hit, hit_total, miss_total, eviction_total,
                  input ready);
  modport sink   (input valid, outcome, extra_hit, hit_total, miss_total, eviction_total,
                  output ready);
endinterface

// ----- rtl/salru_set_store.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// salru_set_store
// One row per set: tags, recency ranks and valid bits of all ways.
// ---------------------------------------------------------------------------
module salru_set_store #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 528
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/salru_way_scan.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// salru_way_scan
// Steps one tag comparator across the ways of a set, one way per cycle,
// tracking first hit, first free way and LRU victim.
// ---------------------------------------------------------------------------
module salru_way_scan #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 62,
  parameter int RANK_W   = 3,
  parameter int WAY_W    = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [WAY_W-1:0]                 last_way,
  input  logic [TAG_W-1:0]                 tag,
  input  logic [MAX_WAYS-1:0]              line_valid,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]  line_rank,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]   line_tag,
  output salru_pkg::scan_stat_t            stat,
  output logic [WAY_W-1:0]                 hit_way,
  output logic [WAY_W-1:0]                 free_way,
  output logic [WAY_W-1:0]                 victim_way,
  output logic [RANK_W-1:0]                best_rank
);

  logic              busy_r;
  logic              done_r;
  logic              hit_r;
  logic              free_r;
  logic [WAY_W-1:0]  w_r;
  logic [WAY_W-1:0]  hit_way_r;
  logic [WAY_W-1:0]  free_way_r;
  logic [WAY_W-1:0]  victim_r;
  logic [RANK_W-1:0] best_r;

  logic              cur_valid;
  logic [RANK_W-1:0] cur_rank;
  logic              cur_match;

  assign cur_valid = line_valid[w_r];
  assign cur_rank  = line_rank[w_r];
  assign cur_match = cur_valid && (line_tag[w_r] == tag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      w_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        w_r    <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (busy_r) begin
        if (!hit_r && cur_match) begin
          hit_r <= 1'b1;
        end
        if (!free_r && !cur_valid) begin
          free_r <= 1'b1;
        end
        if (w_r == last_way) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          w_r <= w_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !start) begin
      if (!hit_r && cur_match) begin
        hit_way_r <= w_r;
      end
      if (!free_r && !cur_valid) begin
        free_way_r <= w_r;
      end
      // greatest rank wins, lowest way on a tie
      if (w_r == '0 || cur_rank > best_r) begin
        best_r   <= cur_rank;
        victim_r <= w_r;
      end
    end
  end

  assign stat       = '{done: done_r, hit: hit_r, free: free_r};
  assign hit_way    = hit_way_r;
  assign free_way   = free_way_r;
  assign victim_way = victim_r;
  assign best_rank  = best_r;

endmodule

// ----- rtl/set_associative_lru_cache_tracker_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// set_associative_lru_cache_tracker_core
// Set-associative cache tracker with LRU replacement and hit/miss/eviction
// counters.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one access per transfer (operation, address).
//   out_ch : one result per access (outcome, extra_hit, saturating totals).
//   APB    : set_bits at 0x0, block_bits at 0x4, ways_in_use at 0x8;
//            write only while idle.
// Sequence: after the input transfer the set is read, each active way passes
//   through the shared tag comparator in turn, the scan is closed, and the
//   row is written back as the result is registered.
// Occupancy: one access is in flight at a time; the way-serial comparator
//   scans the ways of that access one after another.
// Reset: after rst_n the set store is cleared row by row, all
//   2**MAX_SET_BITS rows (64 by default), with in_ch.ready low;
//   configuration writes are taken throughout.
// Stall: a new access is accepted while a result waits; its write-back
//   holds until the waiting result has been transferred.
// ---------------------------------------------------------------------------
module set_associative_lru_cache_tracker_core #(
  parameter int MAX_SET_BITS = salru_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salru_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH   = salru_pkg::DEF_ADDR_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  salru_req_if.sink                        in_ch,
  salru_rsp_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [salru_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [salru_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [salru_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int TAG_W  = ADDR_WIDTH - 2;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int WC_W   = $clog2(MAX_WAYS + 1);
  localparam int SET_W  = MAX_SET_BITS;
  localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
  localparam int SH_W   = $clog2(salru_pkg::BLOCK_BITS_MAX + MAX_SET_BITS + 1);
  localparam int ROW_W  = MAX_WAYS * (TAG_W + RANK_W + 1);
  localparam int CNT_W  = salru_pkg::CNT_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [SET_W-1:0] clr_r;

  logic [salru_pkg::SET_BITS_W-1:0]   set_bits_r;
  logic [salru_pkg::BLOCK_BITS_W-1:0] block_bits_r;
  logic [salru_pkg::WAYS_W-1:0]       ways_r;

  logic [salru_pkg::OP_W-1:0] op_r;
  logic [ADDR_WIDTH-1:0]      addr_r;
  logic [SET_W-1:0]           set_r;
  logic [TAG_W-1:0]           tag_r;

  logic                          out_valid_r;
  logic [salru_pkg::OUTC_W-1:0]  outcome_r;
  logic                          extra_r;
  logic [CNT_W-1:0]              hit_cnt_r;
  logic [CNT_W-1:0]              miss_ctr_r;
  logic [CNT_W-1:0]              evict_cnt_r;
  logic [CNT_W-1:0]              hit_cnt_nxt;
  logic [CNT_W-1:0]              miss_ctr_nxt;
  logic [CNT_W-1:0]              evict_cnt_nxt;

  logic [SB_W-1:0]                       s_eff;
  logic [salru_pkg::BLOCK_BITS_W-1:0]    b_eff;
  logic [WC_W-1:0]                       ways_eff;
  logic [WAY_W-1:0]                      last_way;
  logic [SH_W-1:0]                       tag_sh;
  logic [SET_W-1:0]                      set_idx;
  logic [TAG_W-1:0]                      tag_c;

  logic              in_fire;
  logic              wb_fire;
  logic              cfg_wr;
  logic [1:0]        reg_idx;
  logic              is_modify;

  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [ROW_W-1:0]  rd_row;

  logic [MAX_WAYS-1:0][TAG_W-1:0]  row_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0] row_rank;
  logic [MAX_WAYS-1:0]             row_valid;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;
  logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
  logic [MAX_WAYS-1:0]             new_valid;

  salru_pkg::scan_stat_t scan_stat;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      victim_way;
  logic [RANK_W-1:0]     best_rank;
  logic [WAY_W-1:0]      target;
  logic [RANK_W-1:0]     old_rank;
  logic                  is_fill;

  logic [1:0]       hit_add;
  logic [CNT_W:0]   hit_sum;
  logic [CNT_W:0]   miss_sum;
  logic [CNT_W:0]   evict_sum;

  // ---- configuration ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      salru_pkg::REG_SET_BITS:   prdata = salru_pkg::CFG_DATA_W'(set_bits_r);
      salru_pkg::REG_BLOCK_BITS: prdata = salru_pkg::CFG_DATA_W'(block_bits_r);
      salru_pkg::REG_WAYS:       prdata = salru_pkg::CFG_DATA_W'(ways_r);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    if (set_bits_r == '0) begin
      s_eff = SB_W'(1);
    end else if (int'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = SB_W'(MAX_SET_BITS);
    end else begin
      s_eff = SB_W'(set_bits_r);
    end

    if (block_bits_r == '0) begin
      b_eff = salru_pkg::BLOCK_BITS_W'(1);
    end else if (int'(block_bits_r) > salru_pkg::BLOCK_BITS_MAX) begin
      b_eff = salru_pkg::BLOCK_BITS_W'(salru_pkg::BLOCK_BITS_MAX);
    end else begin
      b_eff = block_bits_r;
    end

    if (ways_r == '0) begin
      ways_eff = WC_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_r);
    end
  end

  assign last_way = WAY_W'(ways_eff - 1'b1);

  // ---- address split ----
  assign tag_sh  = SH_W'(b_eff) + SH_W'(s_eff);
  assign set_idx = SET_W'(addr_r >> b_eff) & ~({SET_W{1'b1}} << s_eff);
  assign tag_c   = TAG_W'(addr_r >> tag_sh);

  // ---- control ----
  assign in_fire   = in_ch.valid && (state_r == ST_IDLE);
  assign wb_fire   = (state_r == ST_WRITE) && (!out_valid_r || out_ch.ready);
  assign is_modify = (op_r == salru_pkg::OP_MODIFY);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_stat.done) state_nxt = ST_WRITE;
      ST_WRITE: if (wb_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      set_bits_r   <= salru_pkg::SET_BITS_RST;
      block_bits_r <= salru_pkg::BLOCK_BITS_RST;
      ways_r       <= salru_pkg::WAYS_RST;
      out_valid_r  <= 1'b0;
      hit_cnt_r    <= '0;
      miss_ctr_r   <= '0;
      evict_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          salru_pkg::REG_SET_BITS:   set_bits_r   <= pwdata[salru_pkg::SET_BITS_W-1:0];
          salru_pkg::REG_BLOCK_BITS: block_bits_r <= pwdata[salru_pkg::BLOCK_BITS_W-1:0];
          salru_pkg::REG_WAYS:       ways_r       <= pwdata[salru_pkg::WAYS_W-1:0];
          default: ;
        endcase
      end
      if (wb_fire) begin
        out_valid_r <= 1'b1;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_ctr_r  <= miss_ctr_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_ch.operation;
      addr_r <= in_ch.address[ADDR_WIDTH-1:0];
    end
    if (state_r == ST_READ) begin
      set_r <= set_idx;
      tag_r <= tag_c;
    end
    if (wb_fire) begin
      outcome_r <= scan_stat.hit  ? salru_pkg::OUT_HIT  :
                   scan_stat.free ? salru_pkg::OUT_MISS : salru_pkg::OUT_EVICT;
      extra_r   <= is_modify;
    end
  end

  // ---- set store and way scan ----
  assign mem_we    = (state_r == ST_CLEAR) || wb_fire;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_r : set_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? '0 : {new_tag, new_rank, new_valid};

  salru_set_store #(
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_set_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state_r == ST_READ),
    .raddr (set_idx),
    .rdata (rd_row)
  );

  assign {row_tag, row_rank, row_valid} = rd_row;

  salru_way_scan #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .RANK_W   (RANK_W),
    .WAY_W    (WAY_W)
  ) u_way_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (state_r == ST_READ),
    .last_way   (last_way),
    .tag        (tag_r),
    .line_valid (row_valid),
    .line_rank  (row_rank),
    .line_tag   (row_tag),
    .stat       (scan_stat),
    .hit_way    (hit_way),
    .free_way   (free_way),
    .victim_way (victim_way),
    .best_rank  (best_rank)
  );

  // ---- write-back row ----
  assign is_fill  = !scan_stat.hit && scan_stat.free;
  assign target   = scan_stat.hit ? hit_way : (scan_stat.free ? free_way : victim_way);
  assign old_rank = scan_stat.hit ? row_rank[hit_way] : best_rank;

  always_comb begin
    new_tag   = row_tag;
    new_rank  = row_rank;
    new_valid = row_valid;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < int'(ways_eff) && WAY_W'(w) != target && row_valid[w] &&
          (is_fill || row_rank[w] < old_rank) && row_rank[w] < RANK_MAX) begin
        new_rank[w] = row_rank[w] + 1'b1;
      end
    end
    new_rank[target]  = '0;
    new_valid[target] = 1'b1;
    if (!scan_stat.hit) begin
      new_tag[target] = tag_r;
    end
  end

  // ---- saturating counters ----
  assign hit_add       = {1'b0, scan_stat.hit} + {1'b0, is_modify};
  assign hit_sum       = {1'b0, hit_cnt_r} + (CNT_W + 1)'(hit_add);
  assign miss_sum      = {1'b0, miss_ctr_r} + (CNT_W + 1)'(!scan_stat.hit);
  assign evict_sum     = {1'b0, evict_cnt_r} +
                         (CNT_W + 1)'(!scan_stat.hit && !scan_stat.free);
  assign hit_cnt_nxt   = hit_sum[CNT_W]   ? '1 : hit_sum[CNT_W-1:0];
  assign miss_ctr_nxt  = miss_sum[CNT_W]  ? '1 : miss_sum[CNT_W-1:0];
  assign evict_cnt_nxt = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];

  // ---- channels ----
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = outcome_r;
  assign out_ch.extra_hit      = extra_r;
  assign out_ch.hit_total      = hit_cnt_r;
  assign out_ch.miss_total     = miss_ctr_r;
  assign out_ch.eviction_total = evict_cnt_r;

endmodule

// ----- rtl/salru_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// salru_checker
// Port-level checks of the cache tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module salru_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [salru_pkg::OUTC_W-1:0] outcome,
  input logic                         extra_hit,
  input logic [salru_pkg::CNT_W-1:0]  hit_total,
  input logic [salru_pkg::CNT_W-1:0]  miss_total,
  input logic [salru_pkg::CNT_W-1:0]  eviction_total
);

  `SALRU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before transfer")
  `SALRU_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready held after an access transfer")
  `SALRU_ASSERT_IMP(a_hit_count, out_valid && (outcome == salru_pkg::OUT_HIT || extra_hit), hit_total != '0, "hit reported with zero hit total")
  `SALRU_ASSERT_IMP(a_miss_count, out_valid && (outcome == salru_pkg::OUT_MISS || outcome == salru_pkg::OUT_EVICT), miss_total != '0, "miss reported with zero miss total")
  `SALRU_ASSERT_IMP(a_evict_le_miss, out_valid, eviction_total <= miss_total, "evictions exceed misses")

endmodule

bind set_associative_lru_cache_tracker_core salru_checker u_salru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .outcome        (out_ch.outcome),
  .extra_hit      (out_ch.extra_hit),
  .hit_total      (out_ch.hit_total),
  .miss_total     (out_ch.miss_total),
  .eviction_total (out_ch.eviction_total)
);
